FILE: rtl/core/hixy_pkg.sv
`default_nettype none

package hixy_pkg;

   localparam int STEP_W  = 33;
   localparam int COORD_W = 17;
   localparam int ORDER_W = 5;

   // Base-4 digit of the zero-based step: which quadrant the sub-square lands in.
   typedef enum logic [1:0] {
      QUAD_TRANSPOSE = 2'd0,
      QUAD_UPPER     = 2'd1,
      QUAD_DIAGONAL  = 2'd2,
      QUAD_MIRROR    = 2'd3
   } hixy_quad_type;

   // Word carried from cell to cell.
   typedef struct packed {
      logic [STEP_W-1:0]  digits;   // remaining digits, current level in [1:0]
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               oor;      // out-of-range; coordinates ride along as zero
   } hixy_word_type;

endpackage

`default_nettype wire

FILE: rtl/core/hixy_cell.sv
`default_nettype none

module hixy_cell #(
   parameter int LEVEL = 0
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [hixy_pkg::ORDER_W-1:0] order,
   input  wire logic                         in_valid,
   input  wire hixy_pkg::hixy_word_type      in_word,
   output logic                              in_ready,
   output logic                              out_valid,
   output hixy_pkg::hixy_word_type           out_word,
   input  wire logic                         out_ready
);
   import hixy_pkg::*;

   localparam logic [COORD_W-1:0] HALF  = COORD_W'(1) << LEVEL;
   localparam logic [COORD_W-1:0] WHOLE = COORD_W'(1) << (LEVEL + 1);
   localparam logic [COORD_W-1:0] ONE   = COORD_W'(1);

   logic          valid_ff;
   hixy_word_type word_ff;
   hixy_word_type word_in;
   logic          active;

   assign active   = (ORDER_W'(LEVEL) < order) && !in_word.oor;
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      word_in        = in_word;
      word_in.digits = in_word.digits >> 2;
      if (active) begin
         case (hixy_quad_type'(in_word.digits[1:0]))
            QUAD_TRANSPOSE: begin
               word_in.x = in_word.y;
               word_in.y = in_word.x;
            end
            QUAD_UPPER: begin
               word_in.y = in_word.y + HALF;
            end
            QUAD_DIAGONAL: begin
               word_in.x = in_word.x + HALF;
               word_in.y = in_word.y + HALF;
            end
            default: begin
               word_in.x = WHOLE - in_word.y + ONE;
               word_in.y = HALF - in_word.x + ONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

FILE: rtl/core/hilbert_index_to_xy.sv
`default_nettype none

// Hilbert curve step-to-coordinate mapper. A request word carries a one-based
// step number; the response word gives the one-based (x, y) grid position of
// that step on a square of side 2^curve_order, or out_of_range with zero
// coordinates when the step is zero or beyond side squared. The order is
// written through the csr port (always ready) and is clamped into 1..MAX_ORDER
// on the write; change it only while no request is in flight. Throughput is one
// word per clock while responses are taken: an intake register followed by a
// chain of MAX_ORDER cells, one per quadrant level, each stage advancing
// independently, so a stalled response only holds the words queued behind it
// and bubbles are squeezed out. A response word is registered in the intake
// register and then once in each cell before it goes valid.
module hilbert_index_to_xy #(
   parameter int MAX_ORDER = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [hixy_pkg::ORDER_W-1:0] csr_curve_order,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [hixy_pkg::STEP_W-1:0]  req_step_number,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [hixy_pkg::COORD_W-1:0]      rsp_coord_x,
   output logic [hixy_pkg::COORD_W-1:0]      rsp_coord_y,
   output logic                              rsp_out_of_range
);
   import hixy_pkg::*;

   localparam logic [ORDER_W-1:0] TOP_ORDER = ORDER_W'(MAX_ORDER);

   // Clamped order; config writes are rare, so clamp once on the write.
   logic [ORDER_W-1:0] order_ff;
   logic [ORDER_W-1:0] order_in;

   assign csr_ready = 1'b1;

   always_comb begin
      order_in = csr_curve_order;
      if (csr_curve_order == '0) begin
         order_in = ORDER_W'(1);
      end else if (csr_curve_order > TOP_ORDER) begin
         order_in = TOP_ORDER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_W'(1);
      end else if (csr_valid && csr_ready) begin
         order_ff <= order_in;
      end
   end

   // Intake: make the step zero-based and range-check it. A step is in range
   // when no bit at or above bit 2*order is set; zero is caught on its own since
   // its wrapped value is flagged by the shift only at orders up to 16.
   logic                      intake_valid_ff;
   hixy_word_type             intake_word_ff;
   hixy_word_type             intake_word_in;
   logic [STEP_W-1:0]         zero_based;
   logic [STEP_W-1:0]         high_digits;
   logic [ORDER_W:0]          shift_amt;
   logic                      step_oor;

   assign zero_based  = req_step_number - STEP_W'(1);
   assign shift_amt   = {order_ff, 1'b0};
   assign high_digits = zero_based >> shift_amt;
   assign step_oor    = (req_step_number == '0) || (high_digits != '0);

   always_comb begin
      intake_word_in.digits = zero_based;
      intake_word_in.oor    = step_oor;
      // Out-of-range words start at zero and pass through the cells untouched.
      intake_word_in.x      = step_oor ? '0 : COORD_W'(1);
      intake_word_in.y      = step_oor ? '0 : COORD_W'(1);
   end

   // Chain plumbing: slot 0 is the intake, slot MAX_ORDER the response.
   logic          chain_valid [MAX_ORDER+1];
   logic          chain_ready [MAX_ORDER+1];
   hixy_word_type chain_word  [MAX_ORDER+1];

   assign req_ready = !intake_valid_ff || chain_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         intake_valid_ff <= 1'b0;
      end else if (req_ready) begin
         intake_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         intake_word_ff <= intake_word_in;
      end
   end

   assign chain_valid[0] = intake_valid_ff;
   assign chain_word[0]  = intake_word_ff;

   // One cell per level, least significant digit first.
   for (genvar k = 0; k < MAX_ORDER; k++) begin : g_level
      hixy_cell #(
         .LEVEL (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .order     (order_ff),
         .in_valid  (chain_valid[k]),
         .in_word   (chain_word[k]),
         .in_ready  (chain_ready[k]),
         .out_valid (chain_valid[k+1]),
         .out_word  (chain_word[k+1]),
         .out_ready (chain_ready[k+1])
      );
   end

   assign chain_ready[MAX_ORDER] = rsp_ready;

   assign rsp_valid        = chain_valid[MAX_ORDER];
   assign rsp_coord_x      = chain_word[MAX_ORDER].x;
   assign rsp_coord_y      = chain_word[MAX_ORDER].y;
   assign rsp_out_of_range = chain_word[MAX_ORDER].oor;

   // An out-of-range word must leave with zero coordinates.
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> rsp_coord_x == '0 && rsp_coord_y == '0)
      else $error("out-of-range word with nonzero coordinates");

   // A zero step is always flagged at intake.
   a_zero_step: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_step_number == '0 |=> intake_word_ff.oor)
      else $error("zero step not flagged");

   // The stored order always lies in the supported range.
   a_order_range: assert property (@(posedge clock) disable iff (reset)
      order_ff != '0 && order_ff <= TOP_ORDER)
      else $error("curve order outside supported range");

   // Reset empties the chain end.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

`default_nettype wire

FILE: verif/hixy_checker.sv
`default_nettype none

module hixy_checker #(
   parameter int MAX_ORDER = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   input  wire logic                         csr_ready,
   input  wire logic [hixy_pkg::ORDER_W-1:0] csr_curve_order,
   input  wire logic                         req_valid,
   input  wire logic                         req_ready,
   input  wire logic [hixy_pkg::STEP_W-1:0]  req_step_number,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire logic [hixy_pkg::COORD_W-1:0] rsp_coord_x,
   input  wire logic [hixy_pkg::COORD_W-1:0] rsp_coord_y,
   input  wire logic                         rsp_out_of_range,
   output int                                mismatches,
   output int                                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import hixy_pkg::*;

   typedef struct packed {
      logic [STEP_W-1:0]  step;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               oor;
   } placement_type;

   placement_type      pending_places[$];
   logic [ORDER_W-1:0] order_reg = 5'd1;
   int                 err_total = 0;

   initial begin
      mismatches = 0;
      outstanding = 0;
   end

   // Walk the quadrant levels from the least significant base-4 digit upward.
   function automatic placement_type place_step(input logic [ORDER_W-1:0] order_cfg,
                                                input logic [STEP_W-1:0] step);
      int unsigned   levels;
      logic [63:0]   cells, d, x, y, half, t;
      hixy_quad_type quad;
      placement_type p;
      levels = order_cfg;
      if (levels < 1) levels = 1;
      if (levels > MAX_ORDER) levels = MAX_ORDER;
      cells = 64'd1 << (2 * levels);
      p.step = step;
      if (step == '0 || {31'b0, step} > cells) begin
         p.x = '0;
         p.y = '0;
         p.oor = 1'b1;
         return p;
      end
      d = {31'b0, step} - 64'd1;
      x = 64'd1;
      y = 64'd1;
      for (int k = 0; k < levels; k++) begin
         half = 64'd1 << k;
         quad = hixy_quad_type'(2'(d >> (2 * k)));
         case (quad)
            QUAD_TRANSPOSE: begin
               t = x;
               x = y;
               y = t;
            end
            QUAD_UPPER: begin
               y = half + y;
            end
            QUAD_DIAGONAL: begin
               x = half + x;
               y = half + y;
            end
            QUAD_MIRROR: begin
               t = 2 * half - y + 1;
               y = half - x + 1;
               x = t;
            end
         endcase
      end
      p.x = x[COORD_W-1:0];
      p.y = y[COORD_W-1:0];
      p.oor = 1'b0;
      return p;
   endfunction

   task automatic flag(input string msg);
      err_total++;
      if (err_total <= 10) $display("%s", msg);
   endtask

   task automatic check_field(input string name, input logic [STEP_W-1:0] step,
                              input logic [COORD_W-1:0] want,
                              input logic [COORD_W-1:0] got);
      if (got !== want)
         flag($sformatf("mismatch on %s for step %0d: expected %0d, got %0d",
                        name, step, want, got));
   endtask

   always @(posedge clock) begin
      placement_type want;
      if (reset) begin
         order_reg = 5'd1;
         pending_places.delete();
      end else begin
         // Retire a result word before queuing a new request word.
         if (rsp_valid && rsp_ready) begin
            if (pending_places.size() == 0) begin
               flag($sformatf("unexpected result word: x %0d y %0d out_of_range %0b",
                              rsp_coord_x, rsp_coord_y, rsp_out_of_range));
            end else begin
               want = pending_places.pop_front();
               check_field("coord_x", want.step, want.x, rsp_coord_x);
               check_field("coord_y", want.step, want.y, rsp_coord_y);
               check_field("out_of_range", want.step, {16'b0, want.oor},
                           {16'b0, rsp_out_of_range});
            end
         end
         if (req_valid && req_ready)
            pending_places.push_back(place_step(order_reg, req_step_number));
         if (csr_valid && csr_ready)
            order_reg = csr_curve_order;
      end
      mismatches <= err_total;
      outstanding <= pending_places.size();
   end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hixy_pkg::*;

   localparam int MAX_ORDER   = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 12;
   localparam int PHASE_WORDS = 88;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic [ORDER_W-1:0] csr_curve_order = '0;
   logic               req_valid = 1'b0;
   logic [STEP_W-1:0]  req_step_number = '0;
   logic               rsp_ready = 1'b0;
   wire                csr_ready;
   wire                req_ready;
   wire                rsp_valid;
   wire [COORD_W-1:0]  rsp_coord_x;
   wire [COORD_W-1:0]  rsp_coord_y;
   wire                rsp_out_of_range;

   int                 mismatches;
   int                 outstanding;
   int                 cycle_count = 0;
   int                 stall_left = 0;
   bit                 idling = 1'b0;     // gaps and stalls allowed in this phase
   int unsigned        side_log = 1;      // order as the block will clamp it

   hilbert_index_to_xy #(.MAX_ORDER(MAX_ORDER)) uut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_curve_order  (csr_curve_order),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_step_number  (req_step_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_coord_x      (rsp_coord_x),
      .rsp_coord_y      (rsp_coord_y),
      .rsp_out_of_range (rsp_out_of_range)
   );

   // The checker watches all three channels, predicts every result word and
   // hands back its mismatch count and the number of words still awaited.
   hixy_checker #(.MAX_ORDER(MAX_ORDER)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_curve_order  (csr_curve_order),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_step_number  (req_step_number),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_coord_x      (rsp_coord_x),
      .rsp_coord_y      (rsp_coord_y),
      .rsp_out_of_range (rsp_out_of_range),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   always #6 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Result side: drop ready in bursts of random length while idling is on,
   // otherwise keep ready high.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 16) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offer one request word; optionally drop valid for a burst first, then
   // hold valid and the step until the block takes the word.
   task automatic send_step(input logic [STEP_W-1:0] step);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_step_number <= step;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait until every predicted word has come back. The first
   // edge lets the checker count a word taken at the current edge.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Write the curve order only with the pipeline empty.
   task automatic write_order(input logic [ORDER_W-1:0] order_val);
      settle();
      csr_valid <= 1'b1;
      csr_curve_order <= order_val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      side_log = (order_val < 1) ? 1 : (order_val > MAX_ORDER) ? MAX_ORDER : order_val;
   endtask

   // Mostly in-range steps with random digits; the rest hit zero, the last
   // cell, just past it, and anything up to the full 33 bits.
   function automatic logic [STEP_W-1:0] pick_step();
      logic [63:0]       cells;
      logic [STEP_W-1:0] raw;
      cells = 64'd1 << (2 * side_log);
      raw = {1'($urandom_range(0, 1)), 32'($urandom())};
      case ($urandom_range(0, 11))
         0: return '0;
         1: return cells[STEP_W-1:0];
         2: return cells[STEP_W-1:0] + 1'b1;
         3: return raw;
         4: return raw | cells[STEP_W-1:0];
         default: return (raw & (cells[STEP_W-1:0] - 1'b1)) + 1'b1;
      endcase
   endfunction

   initial begin
      logic [ORDER_W-1:0] order_val;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset order 1: every quadrant digit, zero, just past the end, all ones.
      send_step(33'd0);
      send_step(33'd1);
      send_step(33'd2);
      send_step(33'd3);
      send_step(33'd4);
      send_step(33'd5);
      send_step(33'h1_FFFF_FFFF);

      // Largest order: uniform digits of each kind, the last cell, one past.
      write_order(5'd16);
      send_step(33'd1);
      send_step(33'd2);
      send_step(33'd3);
      send_step(33'd4);
      send_step(33'h0_5555_5556);
      send_step(33'h0_AAAA_AAAB);
      send_step(33'h1_0000_0000);
      send_step(33'h1_0000_0001);
      send_step(33'd0);

      // Order zero clamps up to one, orders past the top clamp down.
      write_order(5'd0);
      send_step(33'd4);
      send_step(33'd5);
      write_order(5'd31);
      send_step(33'h1_0000_0000);
      send_step(33'h1_0000_0001);
      write_order(5'd2);
      send_step(33'd16);
      send_step(33'd17);

      // Random phases, each under its own order; the last one runs flat out.
      for (int ph = 0; ph < PHASES; ph++) begin
         if ($urandom_range(0, 7) == 0)
            order_val = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
         else
            order_val = 5'($urandom_range(1, 16));
         write_order(order_val);
         idling <= (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
         for (int n = 0; n < PHASE_WORDS; n++) send_step(pick_step());
      end

      // Drain, then keep the clock running a while longer for stray words.
      settle();
      repeat (MAX_ORDER + 4) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
